/* rtl/uwa_pkg.sv */
// ----------------------------------------------------------------------------
// uwa_pkg
// Shared constants and types for the unaligned write aligner: byte lane
// geometry, beat field widths, result queue sizing and the lane result type.
// ----------------------------------------------------------------------------
package uwa_pkg;

    // byte lane geometry of the bus word and of a beat
    localparam int BYTE_W     = 8;
    localparam int LANES      = 8;
    localparam int LANE_IDX_W = 3;
    localparam int DATA_W     = LANES * BYTE_W;
    localparam int CNT_W      = 4;

    // largest byte count a beat can carry
    localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(LANES);

    // input command codes
    localparam logic CMD_IDLE  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // result queue: up to two writes come from one beat
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;
    localparam int QUEUE_CNT_W = 3;

    // what one lane steering unit reports for its output lane
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              head_en;
        logic              spill_en;
    } t_lane_out;

endpackage

/* rtl/uwa_lane.sv */
// ----------------------------------------------------------------------------
// uwa_lane
// Byte steering for one output lane: picks the beat byte that lands on this
// lane and reports whether it belongs to the first word or to the spill word.
// ----------------------------------------------------------------------------
module uwa_lane
    import uwa_pkg::*;
#(
    parameter int LANE = 0
) (
    input  logic [LANE_IDX_W-1:0] i_sub,
    input  logic [CNT_W-1:0]      i_count,
    input  logic [DATA_W-1:0]     i_data,
    output t_lane_out             o_lane
);

    localparam logic [LANE_IDX_W-1:0] LANE_IDX = LANE_IDX_W'(LANE);

    logic [LANE_IDX_W-1:0] w_src;
    logic                  w_in_range;

    // source byte index, modulo the word: same byte for head and spill
    assign w_src      = LANE_IDX - i_sub;
    assign w_in_range = {1'b0, w_src} < i_count;

    // lanes at or above the start offset hold first-word bytes, the rest spill
    always_comb begin
        o_lane.data     = i_data[w_src*BYTE_W +: BYTE_W];
        o_lane.head_en  = w_in_range && (LANE_IDX >= i_sub);
        o_lane.spill_en = w_in_range && (LANE_IDX < i_sub);
    end

endmodule

/* rtl/uwa_out_queue.sv */
// ----------------------------------------------------------------------------
// uwa_out_queue
// Small result queue: takes up to two writes a cycle, hands one a cycle to
// the output channel and holds the head steady while the output stalls.
// ----------------------------------------------------------------------------
module uwa_out_queue
    import uwa_pkg::*;
#(
    parameter int WIDTH = 105
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr0,
    input  logic [WIDTH-1:0] i_data0,
    input  logic             i_wr1,
    input  logic [WIDTH-1:0] i_data1,
    output logic             o_room,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data,
    input  logic             i_stall
);

    logic [WIDTH-1:0]       r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QUEUE_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QUEUE_CNT_W-1:0] r_count, n_count;
    logic [QUEUE_PTR_W-1:0] w_wr_ptr1;
    logic                   w_pop;

    assign w_wr_ptr1 = r_wr_ptr + QUEUE_PTR_W'(1);
    assign w_pop     = (r_count != '0) && !i_stall;

    // pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr + QUEUE_PTR_W'(i_wr0) + QUEUE_PTR_W'(i_wr1);
        n_rd_ptr = r_rd_ptr + QUEUE_PTR_W'(w_pop);
        n_count  = r_count + QUEUE_CNT_W'(i_wr0) + QUEUE_CNT_W'(i_wr1)
                   - QUEUE_CNT_W'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // entry storage, second write goes one slot after the first
    always_ff @(posedge i_clk) begin
        if (i_wr0) begin
            r_mem[r_wr_ptr] <= i_data0;
        end
        if (i_wr1) begin
            r_mem[w_wr_ptr1] <= i_data1;
        end
    end

    // room for a full beat's worth of writes
    assign o_room  = r_count <= QUEUE_CNT_W'(QUEUE_DEPTH - 2);
    assign o_valid = r_count != '0;
    assign o_data  = r_mem[r_rd_ptr];

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QUEUE_CNT_W'(QUEUE_DEPTH))
        else $error("result queue overfilled");

    a_push_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_wr0 && i_wr1) |-> (r_count <= QUEUE_CNT_W'(QUEUE_DEPTH - 2)))
        else $error("two writes pushed without room");

    a_second_after_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr1 |-> i_wr0)
        else $error("second write pushed alone");

endmodule

/* rtl/unaligned_write_aligner.sv */
// ----------------------------------------------------------------------------
// unaligned_write_aligner
// Shifts unaligned write beats into bus-word byte lanes and emits aligned
// writes with byte enables, combining the spill of one beat with a beat that
// continues it.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                  payload
//  input     in         i_in_valid / o_in_stall    command, beat_address,
//                                                   byte_count, beat_data
//  output    out        o_out_valid / i_out_stall  word_address, write_data,
//                                                   byte_enable, last
//
//  A beat is steered, merged with the pending tail and queued in the cycle it
//  is taken; its writes leave in order, one per cycle unless the output stalls.
//  One beat a cycle while each causes one write and the output does not stall;
//  a tail flush plus its own word is two writes, sent in turn (output port limit).
//  The input stalls when the four-entry result queue has fewer than two free.
//  Reset (synchronous, active low) drops any pending tail and empties the queue.
// ----------------------------------------------------------------------------
module unaligned_write_aligner
    import uwa_pkg::*;
#(
    parameter int ADDR_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_command,
    input  logic [ADDR_WIDTH-1:0] i_beat_address,
    input  logic [CNT_W-1:0]      i_byte_count,
    input  logic [DATA_W-1:0]     i_beat_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [ADDR_WIDTH-1:0] o_word_address,
    output logic [DATA_W-1:0]     o_write_data,
    output logic [LANES-1:0]      o_byte_enable,
    output logic                  o_last
);

    localparam int ENTRY_W = ADDR_WIDTH + DATA_W + LANES + 1;

    // pending tail
    logic                  r_tail_valid, n_tail_valid;
    logic [ADDR_WIDTH-1:0] r_tail_addr, n_tail_addr;
    logic [DATA_W-1:0]     r_tail_data, n_tail_data;
    logic [LANES-1:0]      r_tail_be, n_tail_be;
    logic [LANE_IDX_W-1:0] r_tail_pos, n_tail_pos;

    logic                  w_in_acc;
    logic                  w_room;
    logic [CNT_W-1:0]      w_count;
    logic                  w_is_write;
    logic [LANE_IDX_W-1:0] w_sub;
    logic [ADDR_WIDTH-1:0] w_waddr;
    logic                  w_hit;
    t_lane_out             w_lane [LANES];
    logic [DATA_W-1:0]     w_head_d, w_spill_d;
    logic [LANES-1:0]      w_head_be, w_spill_be;
    logic                  w_wr0, w_wr1;
    logic [ENTRY_W-1:0]    w_entry0, w_entry1, w_out_entry;

    assign o_in_stall = !w_room;
    assign w_in_acc   = i_in_valid && !o_in_stall;

    // byte count saturation and beat decode
    assign w_count    = (i_byte_count > MAX_COUNT) ? MAX_COUNT : i_byte_count;
    assign w_is_write = (i_command == CMD_WRITE) && (w_count != '0);
    assign w_sub      = i_beat_address[LANE_IDX_W-1:0];
    assign w_waddr    = {i_beat_address[ADDR_WIDTH-1:LANE_IDX_W], LANE_IDX_W'(0)};

    // one steering unit per output lane
    for (genvar g = 0; g < LANES; g++) begin : g_lane
        uwa_lane #(
            .LANE (g)
        ) u_lane (
            .i_sub   (w_sub),
            .i_count (w_count),
            .i_data  (i_beat_data),
            .o_lane  (w_lane[g])
        );
    end

    // gather lane results into head and spill words
    always_comb begin
        for (int j = 0; j < LANES; j++) begin
            w_head_be[j]                = w_lane[j].head_en;
            w_spill_be[j]               = w_lane[j].spill_en;
            w_head_d[j*BYTE_W +: BYTE_W]  = w_lane[j].head_en ? w_lane[j].data : '0;
            w_spill_d[j*BYTE_W +: BYTE_W] = w_lane[j].spill_en ? w_lane[j].data : '0;
        end
    end

    // a beat continues the tail when it starts exactly where the tail ends
    assign w_hit = r_tail_valid && (w_waddr == r_tail_addr) && (w_sub == r_tail_pos);

    // merge stage: form up to two writes for the accepted beat
    always_comb begin
        w_wr0    = 1'b0;
        w_wr1    = 1'b0;
        w_entry0 = {r_tail_addr, r_tail_data, r_tail_be, 1'b1};
        w_entry1 = {w_waddr, w_head_d, w_head_be, 1'b1};
        if (w_in_acc) begin
            if (w_is_write) begin
                w_wr0 = 1'b1;
                if (w_hit) begin
                    w_entry0 = {r_tail_addr, r_tail_data | w_head_d,
                                r_tail_be | w_head_be, 1'b1};
                end else if (r_tail_valid) begin
                    w_entry0 = {r_tail_addr, r_tail_data, r_tail_be, 1'b0};
                    w_wr1    = 1'b1;
                end else begin
                    w_entry0 = {w_waddr, w_head_d, w_head_be, 1'b1};
                end
            end else begin
                w_wr0 = r_tail_valid;
            end
        end
    end

    // next tail: spill of a taken write beat, else none; kept if no beat taken
    always_comb begin
        n_tail_valid = r_tail_valid;
        n_tail_addr  = r_tail_addr;
        n_tail_data  = r_tail_data;
        n_tail_be    = r_tail_be;
        n_tail_pos   = r_tail_pos;
        if (w_in_acc) begin
            n_tail_valid = w_is_write && (w_spill_be != '0);
            n_tail_addr  = w_waddr + ADDR_WIDTH'(LANES);
            n_tail_data  = w_spill_d;
            n_tail_be    = w_spill_be;
            n_tail_pos   = w_sub + w_count[LANE_IDX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tail_valid <= 1'b0;
        end else begin
            r_tail_valid <= n_tail_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tail_addr <= n_tail_addr;
        r_tail_data <= n_tail_data;
        r_tail_be   <= n_tail_be;
        r_tail_pos  <= n_tail_pos;
    end

    // result queue parts the two sides
    uwa_out_queue #(
        .WIDTH (ENTRY_W)
    ) u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr0   (w_wr0),
        .i_data0 (w_entry0),
        .i_wr1   (w_wr1),
        .i_data1 (w_entry1),
        .o_room  (w_room),
        .o_valid (o_out_valid),
        .o_data  (w_out_entry),
        .i_stall (i_out_stall)
    );

    assign {o_word_address, o_write_data, o_byte_enable, o_last} = w_out_entry;

    a_two_needs_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr1 |-> (r_tail_valid && !w_hit))
        else $error("two writes without a tail to flush");

    a_spill_sets_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && w_is_write && (w_spill_be != '0)) |=> r_tail_valid)
        else $error("spill bytes not kept as tail");

    a_idle_clears_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && !w_is_write) |=> !r_tail_valid)
        else $error("tail survived an idle beat");

    a_enable_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr0 |-> (w_entry0[LANES:1] != '0))
        else $error("write queued with no byte enabled");

endmodule

/* tb/sv/unaligned_write_aligner_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unaligned_write_aligner_tb
// Drives write beats and idle ticks into the aligner with random gaps and
// output stalls. It predicts the aligned writes of every accepted beat from a
// local copy of the pending tail, and checks each write field by field in
// order. One long output hold-off fills the block so that it stalls its input.
// ----------------------------------------------------------------------------
module unaligned_write_aligner_tb;
    import uwa_pkg::*;

    localparam int AW         = 32;
    localparam int ITEMS      = 1650;
    localparam int QUIET_TAIL = 150;
    localparam int HOLD_AT    = 400;
    localparam int HOLD_LEN   = 250;
    localparam int IDLE_LIMIT = 2000;
    localparam int DRAIN_CYC  = 20;

    typedef struct {
        logic              command;
        logic [AW-1:0]     address;
        logic [CNT_W-1:0]  count;
        logic [DATA_W-1:0] data;
    } t_beat;

    typedef struct {
        logic [AW-1:0]     address;
        logic [DATA_W-1:0] data;
        logic [LANES-1:0]  enables;
        logic              last;
    } t_write;

    logic              i_clk          = 1'b0;
    logic              i_rst_n        = 1'b0;
    logic              i_in_valid     = 1'b0;
    logic              i_command      = CMD_IDLE;
    logic [AW-1:0]     i_beat_address = '0;
    logic [CNT_W-1:0]  i_byte_count   = '0;
    logic [DATA_W-1:0] i_beat_data    = '0;
    logic              i_out_stall    = 1'b0;
    logic              o_in_stall;
    logic              o_out_valid;
    logic [AW-1:0]     o_word_address;
    logic [DATA_W-1:0] o_write_data;
    logic [LANES-1:0]  o_byte_enable;
    logic              o_last;

    // beats still to send and writes still to arrive
    t_beat  beat_q[$];
    t_write write_q[$];
    t_beat  cur_beat;

    // local copy of the pending tail
    logic              tail_pending = 1'b0;
    logic [AW-1:0]     tail_addr    = '0;
    logic [DATA_W-1:0] tail_bytes   = '0;
    logic [LANES-1:0]  tail_mask    = '0;
    logic [2:0]        tail_lane    = '0;

    int   beats_total  = ITEMS;
    int   beats_taken  = 0;
    int   error_count  = 0;
    logic timed_out    = 1'b0;
    logic backlog_hold = 1'b0;

    unaligned_write_aligner DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_command      (i_command),
        .i_beat_address (i_beat_address),
        .i_byte_count   (i_byte_count),
        .i_beat_data    (i_beat_data),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_word_address (o_word_address),
        .o_write_data   (o_write_data),
        .o_byte_enable  (o_byte_enable),
        .o_last         (o_last)
    );

    always #5 i_clk = ~i_clk;

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $time, what);
        error_count++;
    endtask

    function automatic t_beat mk_beat(logic cmd, logic [AW-1:0] a, logic [CNT_W-1:0] c,
                                      logic [DATA_W-1:0] d);
        t_beat b;
        b.command = cmd;
        b.address = a;
        b.count   = c;
        b.data    = d;
        return b;
    endfunction

    function automatic logic [DATA_W-1:0] rand_bytes();
        return {$urandom, $urandom};
    endfunction

    // steer one beat into lanes, merge with the tail and queue its writes
    task automatic align_beat(input t_beat b);
        int                n;
        int                off;
        int                lane;
        int                i;
        int                nw;
        logic [AW-1:0]     base;
        logic [DATA_W-1:0] head_d;
        logic [DATA_W-1:0] spill_d;
        logic [LANES-1:0]  head_m;
        logic [LANES-1:0]  spill_m;
        t_write            w[2];
        nw      = 0;
        head_d  = '0;
        spill_d = '0;
        head_m  = '0;
        spill_m = '0;
        n = (b.count > MAX_COUNT) ? int'(MAX_COUNT) : int'(b.count);
        if (b.command == CMD_WRITE && n != 0) begin
            off  = int'(b.address[LANE_IDX_W-1:0]);
            base = {b.address[AW-1:LANE_IDX_W], {LANE_IDX_W{1'b0}}};
            for (i = 0; i < n; i++) begin
                lane = off + i;
                if (lane < LANES) begin
                    head_d[BYTE_W*lane +: BYTE_W] = b.data[BYTE_W*i +: BYTE_W];
                    head_m[lane] = 1'b1;
                end else begin
                    lane -= LANES;
                    spill_d[BYTE_W*lane +: BYTE_W] = b.data[BYTE_W*i +: BYTE_W];
                    spill_m[lane] = 1'b1;
                end
            end
            // a beat that continues the tail shares its write
            if (tail_pending && base == tail_addr && off == int'(tail_lane)) begin
                w[nw] = '{tail_addr, tail_bytes | head_d, tail_mask | head_m, 1'b0};
                nw++;
            end else begin
                if (tail_pending) begin
                    w[nw] = '{tail_addr, tail_bytes, tail_mask, 1'b0};
                    nw++;
                end
                w[nw] = '{base, head_d, head_m, 1'b0};
                nw++;
            end
            if (spill_m != '0) begin
                tail_pending = 1'b1;
                tail_addr    = base + AW'(LANES);
                tail_bytes   = spill_d;
                tail_mask    = spill_m;
                tail_lane    = 3'(off + n - LANES);
            end else begin
                tail_pending = 1'b0;
                tail_addr    = '0;
                tail_bytes   = '0;
                tail_mask    = '0;
                tail_lane    = '0;
            end
        end else begin
            // idle tick or empty beat flushes the tail
            if (tail_pending) begin
                w[nw] = '{tail_addr, tail_bytes, tail_mask, 1'b0};
                nw++;
            end
            tail_pending = 1'b0;
            tail_addr    = '0;
            tail_bytes   = '0;
            tail_mask    = '0;
            tail_lane    = '0;
        end
        if (nw > 0) begin
            w[nw-1].last = 1'b1;
        end
        for (i = 0; i < nw; i++) begin
            write_q.push_back(w[i]);
        end
    endtask

    // input driver: one beat offered at a time, held while stalled
    int send_gap    = 0;
    int in_idle_pct = 0;
    int in_cycle    = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                align_beat(cur_beat);
                beats_taken++;
            end
            if (in_cycle % 100 == 0) begin
                case ($urandom_range(2))
                    0: in_idle_pct = 0;
                    1: in_idle_pct = 4;
                    default: in_idle_pct = 15;
                endcase
            end
            in_cycle++;
            if (!i_in_valid || !o_in_stall) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_in_valid <= 1'b0;
                end else if (!backlog_hold && beats_taken < beats_total - QUIET_TAIL
                             && $urandom_range(99) < in_idle_pct) begin
                    send_gap = $urandom_range(18);
                    i_in_valid <= 1'b0;
                end else if (beat_q.size() != 0) begin
                    cur_beat = beat_q.pop_front();
                    i_in_valid     <= 1'b1;
                    i_command      <= cur_beat.command;
                    i_beat_address <= cur_beat.address;
                    i_byte_count   <= cur_beat.count;
                    i_beat_data    <= cur_beat.data;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // output monitor and stall source
    int     stall_left   = 0;
    int     hold_left    = 0;
    int     out_idle_pct = 0;
    int     out_cycle    = 0;
    logic   backlog_done = 1'b0;
    t_write want;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (write_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected write to %h", o_word_address));
                end else begin
                    want = write_q.pop_front();
                    if (o_word_address !== want.address)
                        report_mismatch($sformatf("word_address %h, expected %h",
                                                  o_word_address, want.address));
                    if (o_write_data !== want.data)
                        report_mismatch($sformatf("write_data %h, expected %h",
                                                  o_write_data, want.data));
                    if (o_byte_enable !== want.enables)
                        report_mismatch($sformatf("byte_enable %b, expected %b",
                                                  o_byte_enable, want.enables));
                    if (o_last !== want.last)
                        report_mismatch($sformatf("last %b, expected %b",
                                                  o_last, want.last));
                end
            end
            if (out_cycle % 100 == 0) begin
                case ($urandom_range(2))
                    0: out_idle_pct = 0;
                    1: out_idle_pct = 4;
                    default: out_idle_pct = 15;
                endcase
            end
            out_cycle++;
            // one long hold-off so the block backs up into its input
            if (!backlog_done && beats_taken >= HOLD_AT) begin
                hold_left    = HOLD_LEN;
                backlog_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else if (beats_taken < beats_total - QUIET_TAIL
                         && $urandom_range(99) < out_idle_pct) begin
                stall_left = $urandom_range(18);
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
            backlog_hold <= (hold_left > 0);
        end
    end

    // watchdog on cycles with no beat moving on either side
    int quiet_cycles = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= IDLE_LIMIT) begin
                timed_out <= 1'b1;
            end
        end
    end

    // stimulus and end of run
    logic [AW-1:0]    a;
    logic [CNT_W-1:0] c;
    int               k;
    int               sel;
    initial begin
        // directed beats
        beat_q.push_back(mk_beat(CMD_IDLE,  32'h0000_0000, 4'd0, '0));
        beat_q.push_back(mk_beat(CMD_WRITE, 32'h0000_0000, 4'd8, '1));
        beat_q.push_back(mk_beat(CMD_WRITE, 32'hFFFF_FFFF, 4'd8, rand_bytes()));
        beat_q.push_back(mk_beat(CMD_WRITE, 32'h0000_0007, 4'd8, rand_bytes()));
        beat_q.push_back(mk_beat(CMD_WRITE, 32'h1000_0003, 4'd4, rand_bytes()));
        beat_q.push_back(mk_beat(CMD_WRITE, 32'h2000_0006, 4'd5, rand_bytes()));
        beat_q.push_back(mk_beat(CMD_WRITE, 32'h2000_000B, 4'd2, rand_bytes()));
        beat_q.push_back(mk_beat(CMD_WRITE, 32'h3000_0007, 4'd1, rand_bytes()));
        beat_q.push_back(mk_beat(CMD_WRITE, 32'h3000_0005, 4'd15, '1));
        beat_q.push_back(mk_beat(CMD_WRITE, 32'h3000_000D, 4'd0, rand_bytes()));
        beat_q.push_back(mk_beat(CMD_WRITE, 32'h4000_0004, 4'd9, rand_bytes()));
        beat_q.push_back(mk_beat(CMD_IDLE,  32'hFFFF_FFFF, 4'd15, '1));
        beat_q.push_back(mk_beat(CMD_WRITE, 32'h5000_0002, 4'd6, '0));
        beat_q.push_back(mk_beat(CMD_WRITE, 32'h0000_0009, 4'd8, rand_bytes()));
        beat_q.push_back(mk_beat(CMD_WRITE, 32'h0000_0012, 4'd3, rand_bytes()));
        beat_q.push_back(mk_beat(CMD_WRITE, 32'h6000_0001, 4'd10, rand_bytes()));
        beat_q.push_back(mk_beat(CMD_WRITE, 32'h6000_0009, 4'd12, rand_bytes()));
        beat_q.push_back(mk_beat(CMD_IDLE,  32'h0000_0000, 4'd0, '0));
        // random part: mostly continuing streams, some noise and broken streams
        while (beat_q.size() < ITEMS) begin
            sel = $urandom_range(9);
            a   = $urandom;
            if ($urandom_range(7) == 0) begin
                a = 32'hFFFF_FFF0 | AW'($urandom_range(15));
            end
            if (sel < 7) begin
                k = $urandom_range(12, 2);
                repeat (k) begin
                    c = CNT_W'($urandom_range(8, 1));
                    beat_q.push_back(mk_beat(CMD_WRITE, a, c, rand_bytes()));
                    a += AW'(c);
                end
                if ($urandom_range(1) == 0) begin
                    beat_q.push_back(mk_beat(CMD_IDLE, $urandom, CNT_W'($urandom_range(15)),
                                             rand_bytes()));
                end
            end else if (sel < 9) begin
                beat_q.push_back(mk_beat(($urandom_range(1) == 0) ? CMD_IDLE : CMD_WRITE,
                                         a, CNT_W'($urandom_range(15)), rand_bytes()));
            end else begin
                c = CNT_W'($urandom_range(8, 1));
                beat_q.push_back(mk_beat(CMD_WRITE, a, c, rand_bytes()));
                a = ($urandom_range(1) == 0) ? a + AW'(c) + 1 : a + AW'(c) - 1;
                beat_q.push_back(mk_beat(CMD_WRITE, a, CNT_W'($urandom_range(8, 1)),
                                         rand_bytes()));
            end
        end
        beats_total = beat_q.size();

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (!timed_out && !(beats_taken == beats_total && write_q.size() == 0)) begin
            @(posedge i_clk);
        end
        if (!timed_out) begin
            repeat (DRAIN_CYC) @(posedge i_clk);
            if (write_q.size() != 0) begin
                report_mismatch($sformatf("%0d writes never arrived", write_q.size()));
            end
        end
        if (timed_out || error_count != 0) begin
            $display("== FAIL ==");
        end else begin
            $display("== PASS ==");
        end
        $finish;
    end

endmodule
